// ===== src/sha_pkg.sv =====
`default_nettype none
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== src/sha_round.sv =====
`default_nettype none
module sha_round (
  input  var logic [255:0] v_i,
  input  var logic [31:0]  k_i,
  input  var logic [31:0]  w_i,
  output var logic [255:0] v_o
);
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
  always_comb begin
    {h, g, f, e, d, c, b, a} = v_i;
    t1 = h + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
         + ((e & f) ^ (~e & g)) + k_i + w_i;
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
    v_o = {g, f, e, d + t1, c, b, a, t1 + t2};
  end
endmodule
`default_nettype wire

// ===== src/sha256_byte_stream_hash_top.sv =====
// SHA-256 over a byte stream.
// Input item on s_axis: tdata = msg_byte; tuser = {end_of_message, byte_present}.
// Output item on m_axis: tdata = digest_word; tuser = {last_word, word_index}.
// Bytes are packed into 16 word memory entries (one write per byte, read
// modify write through a memory with a registered read). A byte that fills
// the block runs the compressor: a load of the 16 words, then 64 rounds (one
// round a cycle, schedule held in a 16-word window), then the add. An
// end-of-message item pads each block in the same memory, compresses
// one or two blocks, then emits eight words H0..H7, the eighth with last set.
// A byte item is accepted and then written; an idle item is only accepted.
// One item is in work at a time; tready is low during the byte write,
// padding, compression and output. A stalled receiver holds the current word.
// Reset restores the initial hash, empties the block and clears the length.
`default_nettype none
module sha256_byte_stream_hash_top (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        s_axis_tvalid,
  output var logic        s_axis_tready,
  input  var logic [7:0]  s_axis_tdata,  // msg_byte
  input  var logic [1:0]  s_axis_tuser,  // end_of_message, byte_present
  output var logic        m_axis_tvalid,
  input  var logic        m_axis_tready,
  output var logic [31:0] m_axis_tdata,  // digest_word
  output var logic [3:0]  m_axis_tuser   // last_word, word_index[2:0]
);
  sha_pkg::state_e st_q, st_d;
  logic [31:0] mem [16];
  logic [31:0] rd_q;
  logic [3:0]  ra, wa;
  logic        we;
  logic [31:0] wd;

  logic [255:0] h_q, h_d, v_q, v_d, v_nx;
  logic [511:0] w_q, w_d;
  logic [5:0]  fill_q, fill_d, cnt_q, cnt_d;
  logic [63:0] bits_q, bits_d, len_q, len_d;
  logic        fin_q, fin_d, two_q, two_d;
  logic        zero_q, zero_d;
  logic [7:0]  byte_q, byte_d;
  logic        pend_q, pend_d;
  logic [2:0]  oi_q, oi_d;
  logic [31:0] wt, wnew, s0, s1, w15, w2;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  assign w15 = w_q[63:32];
  assign w2  = w_q[479:448];
  assign s0 = sha_pkg::ror(w15, 7) ^ sha_pkg::ror(w15, 18) ^ (w15 >> 3);
  assign s1 = sha_pkg::ror(w2, 17) ^ sha_pkg::ror(w2, 19) ^ (w2 >> 10);
  assign wnew = s1 + w_q[319:288] + s0 + w_q[31:0];
  assign wt = w_q[31:0];

  sha_round u_round (.v_i(v_q), .k_i(sha_pkg::round_k(cnt_q)), .w_i(wt), .v_o(v_nx));

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == sha_pkg::ST_IDLE) && !pend_q;

  always_comb begin
    unique case (st_q)
      sha_pkg::ST_IDLE: st_d = pend_q ? sha_pkg::ST_IDLE : st_q;
      default: st_d = st_q;
    endcase
    fill_d = fill_q; cnt_d = cnt_q; bits_d = bits_q; len_d = len_q;
    fin_d = fin_q; two_d = two_q; byte_d = byte_q; pend_d = pend_q;
    zero_d = zero_q;
    oi_d = oi_q; h_d = h_q; v_d = v_q; w_d = w_q;
    ra = fill_q[5:2]; wa = fill_q[5:2]; we = 1'b0; wd = rd_q;
    unique case (st_q)
      sha_pkg::ST_IDLE: begin
        if (accept) begin
          byte_d = s_axis_tdata;
          fin_d = s_axis_tuser[1];
          if (s_axis_tuser[0] || s_axis_tuser[1]) pend_d = 1'b1;
          if (!s_axis_tuser[0] && s_axis_tuser[1]) begin
            pend_d = 1'b0; st_d = sha_pkg::ST_PAD;
            len_d = bits_q + {55'd0, fill_q, 3'd0};
            two_d = (fill_q > 6'd55); cnt_d = 6'd0;
          end
        end else if (pend_q) begin
          pend_d = 1'b0;
          we = 1'b1;
          unique case (fill_q[1:0])
            2'd0: wd = {byte_q, 24'd0};
            2'd1: wd = {rd_q[31:24], byte_q, 16'd0};
            2'd2: wd = {rd_q[31:16], byte_q, 8'd0};
            default: wd = {rd_q[31:8], byte_q};
          endcase
          fill_d = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            bits_d = bits_q + 64'd512;
            cnt_d = 6'd0; st_d = sha_pkg::ST_LOAD; ra = 4'd0;
            len_d = bits_q + 64'd512; two_d = 1'b0;
          end else if (fin_q) begin
            st_d = sha_pkg::ST_PAD; cnt_d = 6'd0;
            len_d = bits_q + {55'd0, fill_q + 6'd1, 3'd0};
            two_d = (fill_q + 6'd1 > 6'd55);
          end
        end
      end
      sha_pkg::ST_PAD: begin
        // cnt: word index 0..15 through the block; fill bytes before pos kept
        ra = cnt_q[3:0]; wa = cnt_q[3:0];
        if (cnt_q[5:4] == 2'd0) begin
          cnt_d = cnt_q + 6'd16;
        end else begin
          we = 1'b1;
          if (zero_q) wd = 32'd0;
          else if ({cnt_q[3:0], 2'd0} + 6'd3 < fill_q) wd = rd_q;
          else if ({cnt_q[3:0], 2'd0} > fill_q) wd = 32'd0;
          else unique case (fill_q[1:0])
            2'd0: wd = 32'h8000_0000;
            2'd1: wd = {rd_q[31:24], 24'h800000};
            2'd2: wd = {rd_q[31:16], 16'h8000};
            default: wd = {rd_q[31:8], 8'h80};
          endcase
          if (!two_q && cnt_q[3:0] == 4'd14) wd = len_q[63:32];
          if (!two_q && cnt_q[3:0] == 4'd15) wd = len_q[31:0];
          if (cnt_q[3:0] == 4'd15) begin
            cnt_d = 6'd0; st_d = sha_pkg::ST_LOAD; ra = 4'd0;
            zero_d = 1'b0;
          end else begin
            cnt_d = {2'b00, cnt_q[3:0] + 4'd1}; ra = cnt_q[3:0] + 4'd1;
            cnt_d = cnt_d + 6'd16;
          end
        end
      end
      sha_pkg::ST_LOAD: begin
        ra = cnt_q[3:0] + 4'd1;
        w_d = {rd_q, w_q[511:32]};
        if (cnt_q == 6'd15) begin
          cnt_d = 6'd0; v_d = h_q; st_d = sha_pkg::ST_ROUND;
        end else cnt_d = cnt_q + 6'd1;
      end
      sha_pkg::ST_ROUND: begin
        v_d = v_nx;
        w_d = {wnew, w_q[511:32]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) st_d = sha_pkg::ST_ADD;
      end
      sha_pkg::ST_ADD: begin
        for (int i = 0; i < 8; i++) h_d[32*i +: 32] = h_q[32*i +: 32] + v_q[32*i +: 32];
        cnt_d = 6'd0;
        if (!fin_q) begin
          fill_d = 6'd0; st_d = sha_pkg::ST_IDLE;
        end else if (two_q) begin
          two_d = 1'b0; fill_d = 6'd0; st_d = sha_pkg::ST_PAD;
          zero_d = 1'b1;
          len_d = len_q;
        end else begin
          oi_d = 3'd0; st_d = sha_pkg::ST_OUT;
        end
      end
      default: begin
        if (m_axis_tready) begin
          oi_d = oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            st_d = sha_pkg::ST_IDLE; fin_d = 1'b0;
            fill_d = 6'd0; bits_d = 64'd0;
            for (int i = 0; i < 8; i++) h_d[32*i +: 32] = sha_pkg::init_h(3'(i));
          end
        end
      end
    endcase
  end

  // A full block that also ends the message: after compressing, pad an
  // empty block (fill 0) with the length.
  logic fullfin_q, fullfin_d;
  always_comb begin
    fullfin_d = fullfin_q;
    if (st_q == sha_pkg::ST_IDLE && !accept && pend_q && fill_q == 6'd63)
      fullfin_d = fin_q;
    else if (st_q == sha_pkg::ST_ADD) fullfin_d = 1'b0;
  end

  logic [5:0]  fill_n;
  logic        two_n;
  logic        fin_n;
  sha_pkg::state_e st_n;
  always_comb begin
    st_n = st_d; fill_n = fill_d; two_n = two_d; fin_n = fin_d;
    if (st_q == sha_pkg::ST_ADD && fullfin_q) begin
      st_n = sha_pkg::ST_PAD; fill_n = 6'd0; two_n = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sha_pkg::ST_IDLE; fill_q <= '0; cnt_q <= '0; bits_q <= '0;
      fin_q <= 1'b0; two_q <= 1'b0; pend_q <= 1'b0; oi_q <= '0; fullfin_q <= 1'b0;
      zero_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[32*i +: 32] <= sha_pkg::init_h(3'(i));
    end else begin
      st_q <= st_n; fill_q <= fill_n; cnt_q <= cnt_d; bits_q <= bits_d;
      fin_q <= fin_n; two_q <= two_n; pend_q <= pend_d; oi_q <= oi_d;
      fullfin_q <= fullfin_d; h_q <= h_d; zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; w_q <= w_d; len_q <= len_d; byte_q <= byte_d;
  end

  assign m_axis_tvalid = (st_q == sha_pkg::ST_OUT);
  assign m_axis_tdata  = h_q[32*oi_q +: 32];
  assign m_axis_tuser  = {oi_q == 3'd7, oi_q};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("digest word changed under stall");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == sha_pkg::ST_ROUND) |-> !s_axis_tready)
    else $error("input taken during compression");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[3] |=> !m_axis_tvalid)
    else $error("output after last word");
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  sha256_byte_stream_hash_top uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  class digest_board;
    logic [31:0]  chain[8];
    logic [7:0]   blk[64];
    int unsigned  fill;
    logic [63:0]  bits;
    digest_item_t pending[$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill = 0;
      bits = '0;
    endfunction

    function logic [31:0] rr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] k[64];
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++)
        w[t] = (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
               (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[t] + w[t];
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) chain[t] += v[t];
    endfunction

    function void note_byte(logic [7:0] data, logic present, logic eom);
      int unsigned pos;
      logic [63:0] len;
      if (present) begin
        blk[fill] = data;
        fill++;
        if (fill == 64) begin
          compress();
          bits += 64'd512;
          fill = 0;
        end
      end
      if (!eom) return;
      pos = fill;
      len = bits + 64'(pos) * 64'd8;
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) blk[i] = '0;
        compress();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) pending.push_back({chain[i], 3'(i), i == 7});
      restart();
    endfunction

    function void check_word(logic [31:0] data, logic [3:0] user);
      digest_item_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h user %h", data, user);
        return;
      end
      e = pending.pop_front();
      if (data !== e.word || user[2:0] !== e.idx || user[3] !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                   e.word, e.idx, e.last, data, user[2:0], user[3]);
      end
    endfunction
  endclass

  digest_board board = new();
  bit rx_quiet = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
      if (m_axis_tvalid && m_axis_tready)
        board.check_word(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= rx_quiet ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  task automatic send_item(logic [7:0] data, logic present, logic eom);
    int g;
    g = gap_len();
    repeat (g) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= {eom, present};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(int n, bit noisy, output int cnt);
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
        cnt++;
      end
      send_item(8'($urandom), 1'b1, 1'b0);
      cnt++;
    end
    if ($urandom_range(0, 1)) send_item(8'($urandom), 1'b0, 1'b1);
    else send_item(8'($urandom), 1'b1, 1'b1);
    cnt++;
  endtask

  initial begin
    int sent, n, k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b0, 1'b1);
    for (int i = 0; i < 7; i++) send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    drain();
    sent = 16;
    while (sent < 480) begin
      case ($urandom_range(0, 5))
        0: n = $urandom_range(54, 57);
        1: n = $urandom_range(62, 66);
        2: n = $urandom_range(118, 130);
        default: n = $urandom_range(0, 20);
      endcase
      if (n > 479 - sent) n = 479 - sent;
      send_message(n, 1'b1, k);
      sent += k;
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    rx_quiet = 1'b1;
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sha256_byte_stream_hash_top.f =====
src/sha_pkg.sv
src/sha_round.sv
src/sha256_byte_stream_hash_top.sv
tb/sv/tb.sv
